### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Clock and reset are aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset
`define MPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that an expression never holds outside reset
`define MPC_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`else

`define MPC_ASSERT(label, prop, msg)
`define MPC_NEVER(label, expr, msg)

`endif

`endif

### hw/rtl/mpc_pkg.sv
`default_nettype none

package mpc_pkg;

    // Number of tracked periods and their positions in every per-period vector
    localparam int NPER      = 6;
    localparam int P_TODAY     = 0;
    localparam int P_YESTERDAY = 1;
    localparam int P_WEEK      = 2;
    localparam int P_MONTH     = 3;
    localparam int P_YEAR      = 4;
    localparam int P_QUARTER   = 5;

    // Field widths
    localparam int READING_BITS = 32;
    localparam int RD_W   = 32;
    localparam int USE_W  = 33;
    localparam int DIFF_W = USE_W + 1;
    localparam int THR_W  = 16;
    localparam int YEAR_W = 12;
    localparam int DOY_W  = 9;

    // Bits of the reading field that carry the meter total
    localparam logic [RD_W-1:0] READING_MASK = (READING_BITS >= RD_W) ? '1 :
        RD_W'((64'(1) << READING_BITS) - 64'(1));

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEEK_START     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_ANCHOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_DAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_ENABLE  = 3'd4;

    // Register values after reset
    localparam logic [2:0]       RST_WEEK_START     = 3'd2;
    localparam logic [3:0]       RST_QUARTER_ANCHOR = 4'd1;
    localparam logic [4:0]       RST_QUARTER_DAY    = 5'd1;
    localparam logic [THR_W-1:0] RST_THRESHOLD      = 16'd10;
    localparam logic [NPER-1:0]  RST_PERIOD_ENABLE  = 6'h3f;

    // Calendar constants
    localparam int MONTHS_PER_YEAR = 12;
    localparam int YEARS_PER_CENTURY = 100;
    // floor(y / 100) as (y * RECIP) >> SHIFT, exact for any 12-bit year
    localparam int CENTURY_RECIP = 5243;
    localparam int CENTURY_SHIFT = 19;

    typedef logic signed [USE_W-1:0] use_t;

    // Word between the baseline stage and the change detector
    typedef struct packed {
        use_t [NPER-1:0] val;
        logic            rolled;
    } period_word_t;

    // Finished result word
    typedef struct packed {
        use_t [NPER-1:0] val;
        logic [NPER-1:0] mask;
        logic            rolled;
    } result_word_t;

    // Gregorian leap-year test without a divider
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [24:0]       prod;
        logic [5:0]        cent;
        logic [YEAR_W-1:0] rem;
        prod = 25'(y) * 25'(CENTURY_RECIP);
        cent = prod[24:CENTURY_SHIFT];
        rem  = y - YEAR_W'(cent) * YEAR_W'(YEARS_PER_CENTURY);
        return (y[1:0] == 2'b00) && ((rem != '0) || (cent[1:0] == 2'b00));
    endfunction

    // Month length; codes outside 1..12 count as 31 days
    function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // True for multiples of three
    function automatic logic mod3_zero(input logic [3:0] x);
        logic z;
        case (x) inside
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: z = 1'b1;
            default:                              z = 1'b0;
        endcase
        return z;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mpc_change_detect.sv
`default_nettype none

module mpc_change_detect (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire mpc_pkg::period_word_t      in_word,
    input  wire logic [mpc_pkg::THR_W-1:0]  threshold,
    input  wire logic [mpc_pkg::NPER-1:0]   enable,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output mpc_pkg::result_word_t           out_word
);
    import mpc_pkg::*;

    logic                            out_valid_reg;
    result_word_t                    out_word_reg;
    result_word_t                    out_word_next;
    use_t       [NPER-1:0]           last_sent_reg;
    use_t       [NPER-1:0]           last_sent_next;
    logic       [NPER-1:0]           sent_once_reg;
    logic       [NPER-1:0]           sent_once_next;
    logic                            adv;

    // Take a new word whenever the output register is free or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign adv       = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Compare each enabled value with the one last sent
    always_comb begin
        logic signed [DIFF_W-1:0] diff;
        logic signed [DIFF_W-1:0] thr;
        logic                     moved;
        thr = $signed({{(DIFF_W-THR_W){1'b0}}, threshold});
        out_word_next.rolled = in_word.rolled;
        last_sent_next = last_sent_reg;
        sent_once_next = sent_once_reg;
        for (int i = 0; i < NPER; i++) begin
            diff  = DIFF_W'(in_word.val[i]) - DIFF_W'(last_sent_reg[i]);
            moved = (diff > thr) || (diff < -thr);
            out_word_next.val[i]  = enable[i] ? in_word.val[i] : '0;
            out_word_next.mask[i] = enable[i] && (!sent_once_reg[i] || moved);
            if (out_word_next.mask[i]) begin
                last_sent_next[i] = in_word.val[i];
                sent_once_next[i] = 1'b1;
            end
        end
    end

    // Hold the result and the sent history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sent_once_reg <= '0;
            last_sent_reg <= '0;
        end else begin
            if (adv) begin
                out_valid_reg <= 1'b1;
                sent_once_reg <= sent_once_next;
                last_sent_reg <= last_sent_next;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (adv) begin
            out_word_reg  <= out_word_next;
        end
    end

`include "assert_macros.svh"

    `MPC_NEVER(a_mask_disabled, out_valid_reg && ((out_word_reg.mask & ~enable) != '0), "mask bit set for a disabled period")
    `MPC_ASSERT(a_sent_after_mask, adv |=> ((sent_once_reg & $past(out_word_next.mask)) == $past(out_word_next.mask)), "flagged period not marked as sent")
    `MPC_ASSERT(a_last_sent_kept, (adv && !out_word_next.mask[P_TODAY]) |=> $stable(last_sent_reg[P_TODAY]), "last sent value moved without a flag")

endmodule

`default_nettype wire

### hw/rtl/meter_period_consumption_core.sv
`default_nettype none

// Meter period consumption core. Each word on the slave stream carries a
// cumulative meter reading in 0.1 litre units and the calendar date; a word
// with reading_valid low is taken and dropped, every other word gives exactly
// one result word with the consumption of today, yesterday, the week, the
// month, the year and the quarter, a mask of the enabled periods whose value
// changed by more than change_threshold since it was last flagged (or was
// never flagged), and a day-rollover flag. The block takes one word per cycle
// while the result side does not stall it. Each taken word is captured in the
// input register, passes the baseline stage (day rollover and the six
// subtractions; the updated baselines feed the next word) and then the change
// detector with its output register. Configuration writes complete at once
// and are meant for idle periods.
module meter_period_consumption_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // tdata: reading[31:0], year[43:32], month[47:44], month_day[52:48],
    //        weekday[55:53], year_day[64:56], zero[71:65]
    input  wire logic [71:0]  s_tdata,
    // tuser: reading_valid[0], date_valid[1]
    input  wire logic [1:0]   s_tuser,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: today_use[32:0], yesterday_use[65:33], week_use[98:66],
    //        month_use[131:99], year_use[164:132], quarter_use[197:165],
    //        zero[199:198]
    output logic [199:0]      m_tdata,
    // tuser: changed_mask[5:0], day_rolled[6]
    output logic [6:0]        m_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [mpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]  cfg_data
);
    import mpc_pkg::*;

    // Configuration registers
    logic [2:0]       week_start_reg;
    logic [3:0]       q_anchor_reg;
    logic [4:0]       q_day_reg;
    logic [THR_W-1:0] threshold_reg;
    logic [NPER-1:0]  enable_reg;

    // Input register
    logic             s0_valid_reg;
    logic [RD_W-1:0]  s0_reading_reg;
    logic             s0_date_valid_reg;
    logic [4:0]       s0_mday_reg;
    logic [2:0]       s0_wday_reg;
    logic [DOY_W-1:0] s0_doy_reg;
    logic             s0_qstart_reg;

    // Baseline state
    logic [RD_W-1:0]  today_base_reg,     today_base_next;
    logic [RD_W-1:0]  yesterday_base_reg, yesterday_base_next;
    logic [RD_W-1:0]  week_base_reg,      week_base_next;
    logic [RD_W-1:0]  month_base_reg,     month_base_next;
    logic [RD_W-1:0]  year_base_reg,      year_base_next;
    logic [RD_W-1:0]  quarter_base_reg,   quarter_base_next;
    logic [DOY_W-1:0] stored_day_reg;

    // Baseline stage output
    logic             a_valid_reg;
    period_word_t     a_word_reg, a_word_next;
    logic             a_ready;
    logic             s0_ready;
    logic             s0_adv;
    logic             roll;
    logic             seen;
    logic             cd_in_ready;

    // Input field views
    logic [RD_W-1:0]   in_reading;
    logic [YEAR_W-1:0] in_year;
    logic [3:0]        in_month;
    logic [4:0]        in_mday;
    logic              in_qstart;

    result_word_t      res_word;

    assign in_reading = s_tdata[31:0] & READING_MASK;
    assign in_year    = s_tdata[43:32];
    assign in_month   = s_tdata[47:44];
    assign in_mday    = s_tdata[52:48];

    // Configuration writes land at once
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            week_start_reg <= RST_WEEK_START;
            q_anchor_reg   <= RST_QUARTER_ANCHOR;
            q_day_reg      <= RST_QUARTER_DAY;
            threshold_reg  <= RST_THRESHOLD;
            enable_reg     <= RST_PERIOD_ENABLE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WEEK_START:     week_start_reg <= cfg_data[2:0];
                CFG_QUARTER_ANCHOR: q_anchor_reg   <= cfg_data[3:0];
                CFG_QUARTER_DAY:    q_day_reg      <= cfg_data[4:0];
                CFG_THRESHOLD:      threshold_reg  <= cfg_data[THR_W-1:0];
                CFG_PERIOD_ENABLE:  enable_reg     <= cfg_data[NPER-1:0];
                default: ;
            endcase
        end
    end

    // Work out whether the incoming date is a quarter restart day
    always_comb begin
        logic [3:0]        anchor;
        logic signed [4:0] mdiff;
        logic [3:0]        mdist;
        logic [4:0]        qday;
        logic [4:0]        lim;
        anchor = ((q_anchor_reg >= 4'd1) && (q_anchor_reg <= 4'(MONTHS_PER_YEAR)))
                 ? q_anchor_reg : 4'd1;
        mdiff  = $signed({1'b0, in_month}) - $signed({1'b0, anchor});
        mdist  = (mdiff < 0) ? 4'(mdiff + 5'sd12) : mdiff[3:0];
        qday   = (q_day_reg == '0) ? 5'd1 : q_day_reg;
        lim    = month_days(is_leap(in_year), in_month);
        if (qday > lim) begin
            qday = lim;
        end
        in_qstart = mod3_zero(mdist) && (in_mday == qday);
    end

    // Pipeline flow
    assign a_ready  = !a_valid_reg || cd_in_ready;
    assign s0_ready = !s0_valid_reg || a_ready;
    assign s_tready = s0_ready;
    assign s0_adv   = s0_valid_reg && a_ready;

    // Capture the input word; drop words without a reading
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (s0_ready) begin
            s0_valid_reg <= s_tvalid && s_tuser[0];
        end
        if (s_tvalid && s0_ready) begin
            s0_reading_reg    <= in_reading;
            s0_date_valid_reg <= s_tuser[1];
            s0_mday_reg       <= in_mday;
            s0_wday_reg       <= s_tdata[55:53];
            s0_doy_reg        <= s_tdata[64:56];
            s0_qstart_reg     <= in_qstart;
        end
    end

    // Roll the baselines on a new day and form the six consumptions
    assign seen = (stored_day_reg != '0);
    assign roll = s0_date_valid_reg && !((s0_doy_reg == stored_day_reg) && seen);

    always_comb begin
        today_base_next     = today_base_reg;
        yesterday_base_next = yesterday_base_reg;
        week_base_next      = week_base_reg;
        month_base_next     = month_base_reg;
        year_base_next      = year_base_reg;
        quarter_base_next   = quarter_base_reg;
        if (roll) begin
            yesterday_base_next = today_base_reg;
            today_base_next     = s0_reading_reg;
            if (seen) begin
                if (s0_wday_reg == week_start_reg) week_base_next = s0_reading_reg;
                if (s0_mday_reg == 5'd1)           month_base_next = s0_reading_reg;
                if (s0_doy_reg == 9'd1)            year_base_next = s0_reading_reg;
                if (s0_qstart_reg)                 quarter_base_next = s0_reading_reg;
            end
        end
        a_word_next.rolled = roll;
        a_word_next.val[P_TODAY] =
            $signed({1'b0, s0_reading_reg}) - $signed({1'b0, today_base_next});
        a_word_next.val[P_YESTERDAY] =
            $signed({1'b0, today_base_next}) - $signed({1'b0, yesterday_base_next});
        a_word_next.val[P_WEEK] =
            $signed({1'b0, s0_reading_reg}) - $signed({1'b0, week_base_next});
        a_word_next.val[P_MONTH] =
            $signed({1'b0, s0_reading_reg}) - $signed({1'b0, month_base_next});
        a_word_next.val[P_YEAR] =
            $signed({1'b0, s0_reading_reg}) - $signed({1'b0, year_base_next});
        a_word_next.val[P_QUARTER] =
            $signed({1'b0, s0_reading_reg}) - $signed({1'b0, quarter_base_next});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg        <= 1'b0;
            today_base_reg     <= '0;
            yesterday_base_reg <= '0;
            week_base_reg      <= '0;
            month_base_reg     <= '0;
            year_base_reg      <= '0;
            quarter_base_reg   <= '0;
            stored_day_reg     <= '0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= s0_valid_reg;
            end
            if (s0_adv) begin
                today_base_reg     <= today_base_next;
                yesterday_base_reg <= yesterday_base_next;
                week_base_reg      <= week_base_next;
                month_base_reg     <= month_base_next;
                year_base_reg      <= year_base_next;
                quarter_base_reg   <= quarter_base_next;
                if (roll) begin
                    stored_day_reg <= s0_doy_reg;
                end
            end
        end
        if (s0_adv) begin
            a_word_reg <= a_word_next;
        end
    end

    // Change detection and output register
    mpc_change_detect u_change (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid_reg),
        .in_ready  (cd_in_ready),
        .in_word   (a_word_reg),
        .threshold (threshold_reg),
        .enable    (enable_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (res_word)
    );

    // Pack the result word
    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < NPER; i++) begin
            m_tdata[i*USE_W +: USE_W] = res_word.val[i];
        end
        m_tuser = {res_word.rolled, res_word.mask};
    end

`include "assert_macros.svh"

    `MPC_ASSERT(a_day_stored, (s0_adv && roll) |=> (stored_day_reg == $past(s0_doy_reg)), "rolled day not stored")
    `MPC_ASSERT(a_yesterday_shift, (s0_adv && roll) |=> (yesterday_base_reg == $past(today_base_reg)), "yesterday baseline not taken from today")
    `MPC_ASSERT(a_no_roll_undated, (s0_adv && !s0_date_valid_reg) |=> ($stable(today_base_reg) && $stable(stored_day_reg)), "baseline moved without a valid date")

endmodule

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;

    import mpc_pkg::*;

    // One meter word as it enters the block
    typedef struct {
        bit [RD_W-1:0]   reading;
        bit              reading_valid;
        bit              date_valid;
        bit [YEAR_W-1:0] year;
        bit [3:0]        month;
        bit [4:0]        mday;
        bit [2:0]        wday;
        bit [DOY_W-1:0]  yday;
    } meter_sample_t;

    // Baseline tracker: keeps its own copy of the baselines and registers and
    // queues the usage word each meter word with a reading should produce
    class usage_scoreboard;
        bit [2:0]        week_start;
        bit [3:0]        anchor_month;
        bit [4:0]        reset_day;
        bit [THR_W-1:0]  threshold;
        bit [NPER-1:0]   enabled;
        bit [RD_W-1:0]   baseline [NPER];
        bit [DOY_W-1:0]  stored_day;
        longint          last_sent [NPER];
        bit              sent_once [NPER];
        result_word_t    pending_usage [$];
        int              errors;

        function new();
            int p;
            week_start   = RST_WEEK_START;
            anchor_month = RST_QUARTER_ANCHOR;
            reset_day    = RST_QUARTER_DAY;
            threshold    = RST_THRESHOLD;
            enabled      = RST_PERIOD_ENABLE;
            stored_day   = '0;
            errors       = 0;
            for (p = 0; p < NPER; p++) begin
                baseline[p]  = '0;
                last_sent[p] = 0;
                sent_once[p] = 1'b0;
            end
        endfunction

        static function int month_length(int y, int m);
            bit leap;
            leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
            case (m)
                2:           return leap ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        // Quarters begin every third month counted from the anchor
        function bit quarter_start(int m);
            int a;
            int mdelta;
            a = (anchor_month >= 1 && anchor_month <= 12) ? int'(anchor_month) : 1;
            mdelta = m - a;
            if (mdelta < 0) mdelta += 12;
            return (mdelta % 3) == 0;
        endfunction

        function void write_register(bit [CFG_IDX_W-1:0] idx, bit [15:0] data);
            case (idx)
                CFG_WEEK_START:     week_start   = data[2:0];
                CFG_QUARTER_ANCHOR: anchor_month = data[3:0];
                CFG_QUARTER_DAY:    reset_day    = data[4:0];
                CFG_THRESHOLD:      threshold    = data[THR_W-1:0];
                CFG_PERIOD_ENABLE:  enabled      = data[NPER-1:0];
                default: ;
            endcase
        endfunction

        function void take_sample(meter_sample_t s);
            result_word_t r;
            longint       rd;
            longint       use_val [NPER];
            longint       delta;
            int           p;
            int           qday;
            int           qlim;
            if (!s.reading_valid) return;
            rd = longint'(s.reading & READING_MASK);
            r.rolled = 1'b0;
            r.mask = '0;

            // Roll the baselines on a new day; a zero day counts as none seen
            if (s.date_valid && !(s.yday == stored_day && stored_day != 0)) begin
                r.rolled = 1'b1;
                baseline[P_YESTERDAY] = baseline[P_TODAY];
                baseline[P_TODAY] = RD_W'(rd);
                if (stored_day != 0) begin
                    if (s.wday == week_start) baseline[P_WEEK] = RD_W'(rd);
                    if (s.mday == 1) baseline[P_MONTH] = RD_W'(rd);
                    if (s.yday == 1) baseline[P_YEAR] = RD_W'(rd);
                    qday = (reset_day == 0) ? 1 : int'(reset_day);
                    qlim = month_length(int'(s.year), int'(s.month));
                    if (qday > qlim) qday = qlim;
                    if (quarter_start(int'(s.month)) && s.mday == qday)
                        baseline[P_QUARTER] = RD_W'(rd);
                end
                stored_day = s.yday;
            end

            for (p = 0; p < NPER; p++)
                use_val[p] = rd - longint'(baseline[p]);
            use_val[P_YESTERDAY] = longint'(baseline[P_TODAY]) -
                                   longint'(baseline[P_YESTERDAY]);

            // Flag periods that moved past the threshold or were never sent
            for (p = 0; p < NPER; p++) begin
                if (!enabled[p]) begin
                    use_val[p] = 0;
                end else begin
                    delta = use_val[p] - last_sent[p];
                    if (delta < 0) delta = -delta;
                    if (!sent_once[p] || delta > longint'(threshold)) begin
                        r.mask[p] = 1'b1;
                        last_sent[p] = use_val[p];
                        sent_once[p] = 1'b1;
                    end
                end
                r.val[p] = use_t'(use_val[p]);
            end
            pending_usage.push_back(r);
        endfunction

        function void report(string what, longint want, longint got);
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, what, want, got);
        endfunction

        function void check_usage(bit [199:0] data, bit [6:0] user);
            string        names [NPER];
            result_word_t want;
            use_t         got;
            int           p;
            names = '{"today_use", "yesterday_use", "week_use",
                      "month_use", "year_use", "quarter_use"};
            if (pending_usage.size() == 0) begin
                errors++;
                $display("%0t: result word with none expected: expected none, actual %h %h",
                         $time, user, data);
                return;
            end
            want = pending_usage.pop_front();
            for (p = 0; p < NPER; p++) begin
                got = data[p*USE_W +: USE_W];
                if (got !== want.val[p])
                    report(names[p], longint'($signed(want.val[p])), longint'(got));
            end
            if (user[NPER-1:0] !== want.mask)
                report("changed_mask", longint'(want.mask), longint'(user[NPER-1:0]));
            if (user[NPER] !== want.rolled)
                report("day_rolled", longint'(want.rolled), longint'(user[NPER]));
        endfunction

        function int waiting();
            return pending_usage.size();
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic [71:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] m_tdata;
    logic [6:0]   m_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]  cfg_data;

    usage_scoreboard tracker;
    int  tx_idle_max;
    int  rx_idle_max;
    bit  drain_hold;

    // Calendar walk for well-formed meter words
    int          cal_year;
    int          cal_month;
    int          cal_mday;
    int          cal_wday;
    int          cal_doy;
    bit [31:0]   meter_total;

    meter_period_consumption_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic meter_sample_t mk(longint rd, int rv, int dv, int y, int m,
                                         int d, int wd, int doy);
        meter_sample_t s;
        s.reading       = RD_W'(rd);
        s.reading_valid = rv[0];
        s.date_valid    = dv[0];
        s.year          = YEAR_W'(y);
        s.month         = 4'(m);
        s.mday          = 5'(d);
        s.wday          = 3'(wd);
        s.yday          = DOY_W'(doy);
        return s;
    endfunction

    // Offer one word after a random gap and note it once taken
    task automatic send_sample(input meter_sample_t s);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {7'd0, s.yday, s.wday, s.mday, s.month, s.year, s.reading};
        s_tuser  <= {s.date_valid, s.reading_valid};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        tracker.take_sample(s);
        @(negedge aclk);
    endtask

    // Write a register; bits above the field width carry junk
    task automatic write_reg(input bit [CFG_IDX_W-1:0] idx, input int val);
        int        w;
        bit [15:0] data;
        case (idx)
            CFG_WEEK_START:     w = 3;
            CFG_QUARTER_ANCHOR: w = 4;
            CFG_QUARTER_DAY:    w = 5;
            CFG_PERIOD_ENABLE:  w = NPER;
            default:            w = 16;
        endcase
        data = (16'($urandom) << w) | 16'(val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        tracker.write_register(idx, data);
        @(negedge aclk);
    endtask

    // Hold until every result is back and the pipeline has drained
    task automatic settle();
        while (tracker.waiting() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic next_day();
        cal_wday = cal_wday % 7 + 1;
        cal_doy++;
        cal_mday++;
        if (cal_mday > usage_scoreboard::month_length(cal_year, cal_month)) begin
            cal_mday = 1;
            cal_month++;
            if (cal_month > 12) begin
                cal_month = 1;
                cal_year++;
                cal_doy = 1;
            end
        end
    endtask

    // Jump to a fresh date, leaning on leap years and month ends
    task automatic jump_date();
        int pick;
        int len;
        int m;
        pick = $urandom_range(0, 5);
        case (pick)
            0:       cal_year = 2000;
            1:       cal_year = 2100;
            2:       cal_year = 2096;
            3:       cal_year = 2399;
            4:       cal_year = 1970;
            default: cal_year = $urandom_range(1970, 2399);
        endcase
        pick = $urandom_range(0, 3);
        cal_month = (pick == 0) ? 2 : (pick == 1) ? 12 : $urandom_range(1, 12);
        len = usage_scoreboard::month_length(cal_year, cal_month);
        cal_mday = $urandom_range(0, 1) ? $urandom_range(len - 3, len)
                                        : $urandom_range(1, len);
        cal_doy = cal_mday;
        for (m = 1; m < cal_month; m++)
            cal_doy += usage_scoreboard::month_length(cal_year, m);
        cal_wday = $urandom_range(1, 7);
    endtask

    // Mostly a walk through the calendar with a rising meter, some noise
    task automatic run_random(input int quota);
        int            taken;
        int            pick;
        meter_sample_t s;
        taken = 0;
        jump_date();
        while (taken < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                s = mk($urandom, $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 4095), $urandom_range(0, 15),
                       $urandom_range(0, 31), $urandom_range(0, 7),
                       $urandom_range(0, 511));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick >= 94)
                    repeat ($urandom_range(2, 9)) next_day();
                else if (pick >= 88)
                    jump_date();
                else if (pick >= 45)
                    next_day();
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    meter_total = $urandom;
                else if (pick < 5)
                    meter_total = 32'hFFFF_FFFF - $urandom_range(0, 40);
                else
                    meter_total += $urandom_range(0, 30);
                s = mk(meter_total, $urandom_range(0, 19) != 0,
                       $urandom_range(0, 19) != 0, cal_year, cal_month,
                       cal_mday, cal_wday, cal_doy);
            end
            send_sample(s);
            if (s.reading_valid) taken++;
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = $urandom_range(0, rx_idle_max);
            if (drain_hold) begin
                drain_hold = 1'b0;
                stall = 120;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            tracker.check_usage(m_tdata, m_tuser);
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        #(3_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        meter_sample_t plan [$];
        int ph;
        int ws;
        int anc;
        int qd;
        int thr;
        int en;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        drain_hold  = 1'b0;
        tx_idle_max = 9;
        rx_idle_max = 9;
        meter_total = 32'd5000;
        tracker = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed words under the reset register values
        plan.push_back(mk(32'hFFFF_FFFF, 0, 1, 2000, 1, 1, 7, 1));  // no reading
        plan.push_back(mk(5, 1, 0, 2000, 1, 1, 7, 1));              // clock not synced
        plan.push_back(mk(100, 1, 1, 2000, 1, 1, 7, 1));            // first day seen
        plan.push_back(mk(105, 1, 1, 2000, 1, 1, 7, 1));
        plan.push_back(mk(130, 1, 1, 2000, 1, 1, 7, 1));
        plan.push_back(mk(200, 1, 1, 2000, 1, 2, 1, 2));
        plan.push_back(mk(300, 1, 1, 2000, 1, 3, 2, 3));            // week start
        plan.push_back(mk(400, 1, 1, 2000, 2, 1, 3, 32));           // month start
        plan.push_back(mk(500, 1, 1, 2000, 4, 1, 7, 92));           // quarter start
        plan.push_back(mk(0, 1, 1, 2000, 4, 1, 7, 92));             // meter below bases
        plan.push_back(mk(32'hFFFF_FFFF, 1, 1, 2000, 4, 1, 7, 92)); // meter at top
        plan.push_back(mk(7, 1, 0, 2000, 4, 10, 2, 101));
        plan.push_back(mk(1000, 1, 1, 2000, 4, 2, 1, 0));           // zero day rolls
        plan.push_back(mk(1001, 1, 1, 2000, 4, 2, 1, 0));           // and rolls again
        plan.push_back(mk(2000, 1, 1, 2001, 1, 1, 2, 1));
        plan.push_back(mk(2500, 1, 1, 2001, 13, 1, 3, 2));          // month out of range
        plan.push_back(mk(2600, 1, 1, 2001, 0, 31, 4, 3));
        plan.push_back(mk(2700, 1, 1, 4095, 15, 0, 0, 366));
        plan.push_back(mk(3000, 1, 1, 2100, 2, 28, 2, 59));
        plan.push_back(mk(3100, 1, 1, 2100, 3, 1, 3, 60));
        foreach (plan[i]) send_sample(plan[i]);
        s_tvalid <= 1'b0;

        for (ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin ws = 1; anc = 12; qd = 31; thr = 0;     en = 63;   end
                1: begin ws = 7; anc = 2;  qd = 29; thr = 65535; en = 'h2A; end
                2: begin ws = 3; anc = 0;  qd = 0;  thr = 10;    en = 0;    end
                3: begin ws = 4; anc = 15; qd = 30; thr = 200;   en = 'h15; end
                4: begin
                    ws  = $urandom_range(1, 7);
                    anc = $urandom_range(1, 12);
                    qd  = $urandom_range(1, 31);
                    thr = $urandom_range(0, 40);
                    en  = $urandom_range(0, 63);
                end
                default: begin
                    ws  = $urandom_range(0, 7);
                    anc = $urandom_range(0, 15);
                    qd  = $urandom_range(0, 31);
                    thr = $urandom_range(0, 15);
                    en  = $urandom_range(1, 63);
                end
            endcase
            write_reg(CFG_WEEK_START, ws);
            write_reg(CFG_QUARTER_ANCHOR, anc);
            write_reg(CFG_QUARTER_DAY, qd);
            write_reg(CFG_THRESHOLD, thr);
            write_reg(CFG_PERIOD_ENABLE, en);
            write_reg(CFG_PERIOD_ENABLE + CFG_IDX_W'($urandom_range(1, 3)), $urandom);
            cfg_valid <= 1'b0;

            // Phase one runs flat out while the result side holds off
            tx_idle_max = (ph == 1 || ph == 2) ? 0 : 9;
            rx_idle_max = (ph == 1 || ph == 3) ? 0 : 9;
            if (ph == 1) drain_hold = 1'b1;
            run_random((ph == 2) ? 60 : 250);
            s_tvalid <= 1'b0;
        end

        while (tracker.waiting() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (tracker.errors == 0 && tracker.waiting() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
